// ----- hdl/nru_pkg.sv -----
// Shared types and constants for the not-recently-used page replacement core.
// No dependencies; imported by every module of the block.
`default_nettype none

package nru_pkg;

   localparam int FRAMES  = 64;
   localparam int VPAGES  = 128;
   localparam int FRAME_W = $clog2(FRAMES);
   localparam int VPAGE_W = $clog2(VPAGES);
   localparam int COUNT_W = $clog2(FRAMES + 1);

   // class = 2*referenced + modified; CLASS_NONE is above every real class
   localparam int          CLASS_W    = 3;
   localparam logic [2:0]  CLASS_NONE = 3'd4;

   typedef struct packed {
      logic               op;
      logic [VPAGE_W-1:0] vpage;
      logic               is_write;
   } req_type;

   typedef struct packed {
      logic               miss;
      logic [FRAME_W-1:0] frame;
      logic               evicted_valid;
      logic [VPAGE_W-1:0] evicted_vpage;
      logic               evicted_dirty;
   } rsp_type;

   localparam logic OP_ACCESS = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SCAN,
      ST_OWNER,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      KIND_TICK,
      KIND_HIT,
      KIND_FILL,
      KIND_EVICT
   } kind_type;

endpackage

`default_nettype wire

// ----- hdl/nru_scan.sv -----
// Victim search: one frame class compared per cycle against the running best.
// Depends on nru_pkg.
`default_nettype none

module nru_scan import nru_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [FRAMES-1:0]  ref_bits,
   input  wire logic [FRAMES-1:0]  dirty_bits,
   output logic                    done,
   output logic [FRAME_W-1:0]      victim
);

   localparam logic [FRAME_W-1:0] LAST_IDX = FRAME_W'(FRAMES - 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [FRAME_W-1:0] idx_ff, idx_in;
   logic [FRAME_W-1:0] best_ff, best_in;
   logic [CLASS_W-1:0] best_cls_ff, best_cls_in;
   logic [CLASS_W-1:0] cls;

   assign cls = {1'b0, ref_bits[idx_ff], dirty_bits[idx_ff]};

   always_comb begin
      busy_in     = busy_ff;
      done_in     = 1'b0;
      idx_in      = idx_ff;
      best_in     = best_ff;
      best_cls_in = best_cls_ff;
      if (start) begin
         busy_in     = 1'b1;
         idx_in      = '0;
         best_in     = '0;
         best_cls_in = CLASS_NONE;
      end else if (busy_ff) begin
         // strict compare keeps the lowest index on a tie
         if (cls < best_cls_ff) begin
            best_in     = idx_ff;
            best_cls_in = cls;
         end
         if (idx_ff == LAST_IDX) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      idx_ff      <= idx_in;
      best_ff     <= best_in;
      best_cls_ff <= best_cls_in;
   end

   assign done   = done_ff;
   assign victim = best_ff;

endmodule

`default_nettype wire

// ----- hdl/nru_page_replacement_core.sv -----
// Top level of the not-recently-used page replacement core.
// Depends on nru_pkg and nru_scan.
//
// Usage:
//   req channel (req_valid/req_stall/req) carries one beat per access or
//   clock tick. rsp channel (rsp_valid/rsp_stall/rsp) returns exactly one
//   beat per request, in order.
//   From the accepting edge to the output register, a tick, a hit or a
//   miss that fills a free frame passes the lookup and done states; a miss
//   that must evict also passes the scan and owner states, since the victim
//   search visits one frame per cycle through the shared class comparator.
//   Throughput: one request in flight; req_stall is high from the accepting
//   edge until the result is loaded into the output register. A new request
//   is taken while an earlier result still waits in that register.
//   When the receiver stalls, the finished result holds the sequencer in its
//   final state until the output register frees up.
//   Reset (synchronous) empties every frame, clears referenced and modified
//   bits and drops any pending result; no clearing pass is needed.
`default_nettype none

module nru_page_replacement_core import nru_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp
);

   state_type state_ff, state_in;
   kind_type  kind_ff, kind_in;

   req_type            req_ff;
   logic [FRAME_W-1:0] target_ff, target_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [FRAMES-1:0]  ref_ff, ref_in;
   logic [FRAMES-1:0]  dirty_ff, dirty_in;
   logic [VPAGES-1:0]  present_ff, present_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   // frame -> owning page, page -> frame; contents undefined until written
   logic [VPAGE_W-1:0] owner_mem [FRAMES];
   logic [FRAME_W-1:0] pframe_mem [VPAGES];
   logic [VPAGE_W-1:0] owner_rd_ff;
   logic [FRAME_W-1:0] pframe_rd_ff;

   logic               req_accept;
   logic               fire;
   logic               scan_start;
   logic               scan_done;
   logic [FRAME_W-1:0] scan_victim;
   logic               is_full;
   logic               page_hit;
   logic               load_page;

   assign req_accept = req_valid && !req_stall;
   assign is_full    = (count_ff == COUNT_W'(FRAMES));
   assign page_hit   = present_ff[req_ff.vpage];
   assign load_page  = fire && (kind_ff == KIND_FILL || kind_ff == KIND_EVICT);

   nru_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .start      (scan_start),
      .ref_bits   (ref_ff),
      .dirty_bits (dirty_ff),
      .done       (scan_done),
      .victim     (scan_victim)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_accept) state_in = ST_LOOKUP;
         ST_LOOKUP: begin
            if (req_ff.op == OP_ACCESS && !page_hit && is_full) state_in = ST_SCAN;
            else state_in = ST_DONE;
         end
         ST_SCAN:   if (scan_done) state_in = ST_OWNER;
         ST_OWNER:  state_in = ST_DONE;
         ST_DONE:   if (fire) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_stall  = 1'b1;
      scan_start = 1'b0;
      fire       = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_stall = reset;
         ST_LOOKUP: scan_start = (req_ff.op == OP_ACCESS) && !page_hit && is_full;
         ST_SCAN:   ;
         ST_OWNER:  ;
         ST_DONE:   fire = !rsp_valid_ff || !rsp_stall;
         default:   ;
      endcase
   end

   // Classify the request and pick the frame it lands in
   always_comb begin
      kind_in   = kind_ff;
      target_in = target_ff;
      if (state_ff == ST_LOOKUP) begin
         if (req_ff.op == OP_TICK) begin
            kind_in   = KIND_TICK;
            target_in = '0;
         end else if (page_hit) begin
            kind_in   = KIND_HIT;
            target_in = pframe_rd_ff;
         end else if (!is_full) begin
            // frames fill in order and are never freed, so the count is the
            // lowest free frame
            kind_in   = KIND_FILL;
            target_in = count_ff[FRAME_W-1:0];
         end else begin
            kind_in = KIND_EVICT;
         end
      end else if (state_ff == ST_SCAN && scan_done) begin
         target_in = scan_victim;
      end
   end

   // Frame and page bookkeeping, applied when the result is loaded
   always_comb begin
      ref_in     = ref_ff;
      dirty_in   = dirty_ff;
      present_in = present_ff;
      count_in   = count_ff;
      if (fire) begin
         case (kind_ff) inside
            KIND_TICK: ref_in = '0;
            KIND_HIT: begin
               ref_in[target_ff] = 1'b1;
               if (req_ff.is_write) dirty_in[target_ff] = 1'b1;
            end
            KIND_FILL, KIND_EVICT: begin
               ref_in[target_ff]   = 1'b1;
               dirty_in[target_ff] = req_ff.is_write;
               if (kind_ff == KIND_EVICT) present_in[owner_rd_ff] = 1'b0;
               else count_in = count_ff + 1'b1;
               present_in[req_ff.vpage] = 1'b1;
            end
            default: ;
         endcase
      end
   end

   // Result beat
   always_comb begin
      rsp_in               = rsp_ff;
      rsp_in.miss          = (kind_ff == KIND_FILL) || (kind_ff == KIND_EVICT);
      rsp_in.frame         = target_ff;
      rsp_in.evicted_valid = (kind_ff == KIND_EVICT);
      rsp_in.evicted_vpage = (kind_ff == KIND_EVICT) ? owner_rd_ff : '0;
      rsp_in.evicted_dirty = (kind_ff == KIND_EVICT) ? dirty_ff[target_ff] : 1'b0;
      if (!fire) rsp_in = rsp_ff;

      rsp_valid_in = rsp_valid_ff;
      if (fire) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ref_ff       <= '0;
         dirty_ff     <= '0;
         present_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ref_ff       <= ref_in;
         dirty_ff     <= dirty_in;
         present_ff   <= present_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff   <= kind_in;
      target_ff <= target_in;
      rsp_ff    <= rsp_in;
      if (req_accept) req_ff <= req;
   end

   // Page table: read on accept, written when a page is loaded
   always_ff @(posedge clock) begin
      if (req_accept) pframe_rd_ff <= pframe_mem[req.vpage];
      if (load_page) pframe_mem[req_ff.vpage] <= target_ff;
   end

   // Frame owner table: read at the current target every cycle
   always_ff @(posedge clock) begin
      owner_rd_ff <= owner_mem[target_ff];
      if (load_page) owner_mem[target_ff] <= req_ff.vpage;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

// ----- hdl/nru_checker.sv -----
// Port-level checks for the page replacement core, bound to its top level.
// Depends on nru_pkg and nru_page_replacement_core.
`default_nettype none

module nru_checker import nru_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp
);

   // one request in flight: the block goes busy right after taking a beat
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one still in flight");

   // an eviction only happens on a miss
   a_evict_on_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.evicted_valid |-> rsp.miss)
      else $error("eviction reported without a miss");

   // eviction fields are zero when nothing was evicted
   a_evict_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp.evicted_valid |-> rsp.evicted_vpage == '0 && !rsp.evicted_dirty)
      else $error("stray eviction fields");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("stalled result beat changed");

endmodule

bind nru_page_replacement_core nru_checker u_nru_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp)
);

`default_nettype wire
